// ===== rtl/core/rild_pkg.sv =====
// ----------------------------------------------------------------------------
// rild_pkg
// Types, codes and widths shared by the run/increment length decoder.
// ----------------------------------------------------------------------------
package rild_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int CNT_BITS    = LENGTH_BITS + 1;
  localparam int HDR_BITS    = 24;
  localparam int EXT_BITS    = (LENGTH_BITS > HDR_BITS) ? LENGTH_BITS : HDR_BITS;
  localparam int REM_BITS    = 7;

  typedef enum logic [1:0] {
    OP_COPY = 2'd0,
    OP_INC  = 2'd1,
    OP_RUN  = 2'd2,
    OP_DEC  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_SHORT   = 2'd1,
    STS_OVERRUN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_HEADER,
    S_CMD,
    S_COPY_LO,
    S_COPY_HI,
    S_SEED_LO,
    S_SEED_HI,
    S_EXPAND,
    S_DONE,
    S_ERROR
  } state_t;

  typedef enum logic [1:0] {
    EMIT_STATUS,
    EMIT_LIT_NARROW,
    EMIT_LIT_WIDE,
    EMIT_PAIR
  } emit_kind_t;

  typedef struct packed {
    logic       hdr_load;
    logic       cmd_load;
    logic       low_load;
    logic       lit_adv;
    logic       lit_wide;
    logic       seed_load;
    logic       seed_wide;
    logic       exp_step;
    logic       clear;
    logic       emit;
    emit_kind_t emit_kind;
    status_t    emit_status;
    logic       emit_last;
    logic       emit_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic wide;
    logic out_free;
    logic hdr_last;
    logic is_copy;
    logic overrun;
    logic lit_last;
    logic lit_fin1;
    logic lit_fin2;
    logic exp_last;
    logic exp_fin;
  } dp_stat_t;

  function automatic logic [LENGTH_BITS-1:0] len_trunc(input logic [HDR_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    return ext[LENGTH_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/rild_datapath.sv =====
// ----------------------------------------------------------------------------
// rild_datapath
// Stream counters, command registers, run expansion and result register.
// ----------------------------------------------------------------------------
module rild_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic [7:0]         byte_in,
  input  rild_pkg::dp_cmd_t  cmd,
  output rild_pkg::dp_stat_t stat,
  input  logic               m_ready,
  output logic               m_valid,
  output logic [39:0]        m_data,
  output logic               m_last,
  output logic               m_user
);
  import rild_pkg::*;

  logic [1:0]             word_bytes;
  logic [2:0]             hdr_idx;
  logic [LENGTH_BITS-1:0] out_len;
  logic [CNT_BITS-1:0]    ww;
  logic [REM_BITS-1:0]    rem;
  opcode_t                opcode;
  logic [7:0]             low_byte;
  logic [15:0]            val;
  logic                   exp_wide;
  logic                   exp_fin_q;

  logic                   out_valid;
  logic [15:0]            out_first;
  logic [15:0]            out_second;
  logic [1:0]             out_count;
  status_t                out_status;
  logic                   out_last;
  logic                   out_fin;

  opcode_t                opc_in;
  logic [REM_BITS-1:0]    rem_in;
  logic [7:0]             need_bytes;
  logic [CNT_BITS:0]      sum_chk;
  logic [CNT_BITS-1:0]    len_ext;
  logic [CNT_BITS-1:0]    ww_p1;
  logic [CNT_BITS-1:0]    ww_p2;
  logic [7:0]             seed_bytes;
  logic [CNT_BITS-1:0]    ww_seed;
  logic [15:0]            seed_in;
  logic [1:0]             hdr_sel;
  logic [HDR_BITS-1:0]    hdr_word;
  logic [15:0]            mask;
  logic [15:0]            step;
  logic [15:0]            step2;
  logic [15:0]            v1;
  logic [15:0]            v2;

  always_comb begin
    opc_in     = opcode_t'(byte_in[7:6]);
    rem_in     = REM_BITS'(byte_in[5:0]) +
                 ((opc_in == OP_COPY) ? REM_BITS'(1) : REM_BITS'(3));
    need_bytes = word_bytes[1] ? {rem_in, 1'b0} : {1'b0, rem_in};
    len_ext    = CNT_BITS'(out_len);
    sum_chk    = (CNT_BITS+1)'(ww) + (CNT_BITS+1)'(need_bytes);
    ww_p1      = ww + CNT_BITS'(1);
    ww_p2      = ww + CNT_BITS'(2);
    seed_bytes = cmd.seed_wide ? {rem, 1'b0} : {1'b0, rem};
    ww_seed    = ww + CNT_BITS'(seed_bytes);
    seed_in    = cmd.seed_wide ? {byte_in, low_byte} : {8'h00, byte_in};
    hdr_sel    = hdr_idx[1:0] - 2'd1;
    hdr_word   = HDR_BITS'(byte_in) << {hdr_sel, 3'b000};
    mask       = exp_wide ? 16'hFFFF : 16'h00FF;
    case (opcode)
      OP_INC:  step = 16'h0001;
      OP_DEC:  step = 16'hFFFF;
      default: step = 16'h0000;
    endcase
    step2 = {step[14:0], 1'b0};
    v1    = (val + step) & mask;
    v2    = (val + step2) & mask;
  end

  always_comb begin
    stat.wide     = word_bytes[1];
    stat.out_free = !out_valid || m_ready;
    stat.hdr_last = (hdr_idx == 3'd3);
    stat.is_copy  = (opc_in == OP_COPY);
    stat.overrun  = sum_chk > (CNT_BITS+1)'(out_len);
    stat.lit_last = (rem == REM_BITS'(1));
    stat.lit_fin1 = stat.lit_last && (ww_p1 == len_ext);
    stat.lit_fin2 = stat.lit_last && (ww_p2 == len_ext);
    stat.exp_last = (rem <= REM_BITS'(2));
    stat.exp_fin  = exp_fin_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bytes <= 2'd1;
    end else if (cfg_wr_en) begin
      word_bytes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      hdr_idx   <= '0;
      out_len   <= '0;
      ww        <= '0;
      rem       <= '0;
      opcode    <= OP_COPY;
      low_byte  <= '0;
      val       <= '0;
      exp_wide  <= 1'b0;
      exp_fin_q <= 1'b0;
    end else begin
      if (cmd.hdr_load) begin
        hdr_idx <= hdr_idx + 3'd1;
        if (hdr_idx != 3'd0) begin
          out_len <= out_len | len_trunc(hdr_word);
        end
      end
      if (cmd.cmd_load) begin
        opcode <= opc_in;
        rem    <= rem_in;
      end
      if (cmd.low_load) begin
        low_byte <= byte_in;
      end
      if (cmd.lit_adv) begin
        ww  <= cmd.lit_wide ? ww_p2 : ww_p1;
        rem <= rem - REM_BITS'(1);
      end
      if (cmd.seed_load) begin
        val       <= seed_in;
        exp_wide  <= cmd.seed_wide;
        ww        <= ww_seed;
        exp_fin_q <= (ww_seed == len_ext);
      end
      if (cmd.exp_step) begin
        val <= v2;
        rem <= stat.exp_last ? '0 : rem - REM_BITS'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_last   <= cmd.emit_last;
      out_fin    <= cmd.emit_fin;
      case (cmd.emit_kind)
        EMIT_LIT_NARROW: begin
          out_first  <= {8'h00, byte_in};
          out_second <= '0;
          out_count  <= 2'd1;
        end
        EMIT_LIT_WIDE: begin
          out_first  <= {byte_in, low_byte};
          out_second <= '0;
          out_count  <= 2'd1;
        end
        EMIT_PAIR: begin
          out_first  <= val;
          out_second <= (rem == REM_BITS'(1)) ? 16'h0000 : v1;
          out_count  <= (rem == REM_BITS'(1)) ? 2'd1 : 2'd2;
        end
        default: begin
          out_first  <= '0;
          out_second <= '0;
          out_count  <= 2'd0;
        end
      endcase
    end
  end

  assign m_valid = out_valid;
  assign m_data  = {4'b0000, out_status, out_count, out_second, out_first};
  assign m_last  = out_last;
  assign m_user  = out_fin;

  a_status_only_flagged: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_data[33:32] == 2'd0) |-> (m_data[35:34] != 2'd0))
    else $error("status-only result without a status code");

  a_fin_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_user) |-> m_last)
    else $error("finished flag on a result that is not last of its byte");

  a_step_has_words: assert property (@(posedge clk) disable iff (rst)
    cmd.exp_step |-> (rem != '0))
    else $error("expansion step with no words left");

endmodule

// ===== rtl/core/rild_ctrl.sv =====
// ----------------------------------------------------------------------------
// rild_ctrl
// Stream phase controller: header, commands, literals, seeds and expansion.
// ----------------------------------------------------------------------------
module rild_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  input  logic               s_last,
  output logic               s_ready,
  input  rild_pkg::dp_stat_t stat,
  output rild_pkg::dp_cmd_t  cmd
);
  import rild_pkg::*;

  state_t state;
  state_t state_next;
  logic   eos_held;
  logic   eos_held_next;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_HEADER;
      eos_held <= 1'b0;
    end else begin
      state    <= state_next;
      eos_held <= eos_held_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    eos_held_next = eos_held;
    s_ready       = (state != S_EXPAND) && stat.out_free;
    acc           = s_valid && s_ready;

    unique case (state)
      S_HEADER: begin
        if (acc) begin
          cmd.hdr_load = 1'b1;
          if (stat.hdr_last) begin
            state_next = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (acc) begin
          cmd.cmd_load = 1'b1;
          if (!s_last && stat.overrun) begin
            cmd.emit        = 1'b1;
            cmd.emit_kind   = EMIT_STATUS;
            cmd.emit_status = STS_OVERRUN;
            cmd.emit_last   = 1'b1;
            state_next      = S_ERROR;
          end else begin
            state_next = stat.is_copy ? S_COPY_LO : S_SEED_LO;
          end
        end
      end
      S_COPY_LO: begin
        if (acc) begin
          if (stat.wide) begin
            cmd.low_load = 1'b1;
            state_next   = S_COPY_HI;
          end else begin
            cmd.lit_adv   = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = EMIT_LIT_NARROW;
            cmd.emit_last = 1'b1;
            cmd.emit_fin  = stat.lit_fin1;
            if (stat.lit_last) begin
              state_next = stat.lit_fin1 ? S_DONE : S_CMD;
            end
          end
        end
      end
      S_COPY_HI: begin
        if (acc) begin
          cmd.lit_adv   = 1'b1;
          cmd.lit_wide  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_LIT_WIDE;
          cmd.emit_last = 1'b1;
          cmd.emit_fin  = stat.lit_fin2;
          if (stat.lit_last) begin
            state_next = stat.lit_fin2 ? S_DONE : S_CMD;
          end else begin
            state_next = S_COPY_LO;
          end
        end
      end
      S_SEED_LO: begin
        if (acc) begin
          if (stat.wide) begin
            cmd.low_load = 1'b1;
            state_next   = S_SEED_HI;
          end else begin
            cmd.seed_load = 1'b1;
            eos_held_next = s_last;
            state_next    = S_EXPAND;
          end
        end
      end
      S_SEED_HI: begin
        if (acc) begin
          cmd.seed_load = 1'b1;
          cmd.seed_wide = 1'b1;
          eos_held_next = s_last;
          state_next    = S_EXPAND;
        end
      end
      S_EXPAND: begin
        if (stat.out_free) begin
          cmd.exp_step  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_PAIR;
          if (stat.exp_last) begin
            cmd.emit_last   = 1'b1;
            cmd.emit_fin    = stat.exp_fin;
            cmd.emit_status = (eos_held && !stat.exp_fin) ? STS_SHORT : STS_OK;
            eos_held_next   = 1'b0;
            if (eos_held) begin
              cmd.clear  = 1'b1;
              state_next = S_HEADER;
            end else begin
              state_next = stat.exp_fin ? S_DONE : S_CMD;
            end
          end
        end
      end
      S_DONE, S_ERROR: begin
      end
      default: begin
        state_next = S_HEADER;
      end
    endcase

    // end of stream on a byte that does not start an expansion
    if (acc && s_last && state_next != S_EXPAND) begin
      if (cmd.emit) begin
        if (!cmd.emit_fin && cmd.emit_status == STS_OK) begin
          cmd.emit_status = STS_SHORT;
        end
      end else if (state != S_DONE && state != S_ERROR) begin
        cmd.emit        = 1'b1;
        cmd.emit_kind   = EMIT_STATUS;
        cmd.emit_status = STS_SHORT;
        cmd.emit_last   = 1'b1;
      end
      cmd.clear  = 1'b1;
      state_next = S_HEADER;
    end
  end

  a_no_input_in_expand: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXPAND) |-> !s_ready)
    else $error("input taken during run expansion");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written over an untaken result");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (state == S_DONE || state == S_HEADER))
    else $error("left completed state without end of stream");

endmodule

// ===== rtl/core/run_increment_length_decoder.sv =====
// ----------------------------------------------------------------------------
// run_increment_length_decoder
// Run/increment/decrement length decoder, one compressed byte per beat.
// ----------------------------------------------------------------------------
// Input stream: one compressed byte per beat on s_axis_tdata, s_axis_tlast
// marks the final byte of a stream; the next byte starts a new header.
// Output stream: one result per beat, up to two decoded words. m_axis_tlast
// marks the last result of an input byte, m_axis_tuser marks completion.
// cfg_wr_en/cfg_wr_data set the word size (bit 1 set: 16-bit words); write
// only while the block is idle.
// Throughput: header, command and literal bytes are accepted while the output
// register is free. A seed byte starts an expansion that emits one result (two
// words, the last may hold one) per cycle while results are taken, L+3 words
// in all; input is held off meanwhile. Each result sits in the single output
// register from the cycle after the byte or expansion step that makes it.
// Backpressure: a held result blocks new input and expansion until taken.
// Reset: synchronous; clears stream state and selects 8-bit words.
// ----------------------------------------------------------------------------
module run_increment_length_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,     // word_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] byte_in
  input  logic        s_axis_tlast,    // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] word_first, [31:16] word_second, [33:32] word_count,
  // [35:34] status, [39:36] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,    // last_of_run
  output logic [0:0]  m_axis_tuser     // [0] finished
);
  import rild_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     fin;

  rild_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_last  (s_axis_tlast),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rild_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_in     (s_axis_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .m_ready     (m_axis_tready),
    .m_valid     (m_axis_tvalid),
    .m_data      (m_axis_tdata),
    .m_last      (m_axis_tlast),
    .m_user      (fin)
  );

  assign m_axis_tuser = fin;

endmodule

// ===== bench/run_increment_length_decoder_test.sv =====
// ----------------------------------------------------------------------------
// run_increment_length_decoder_test
// Self-checking bench for the run/increment length decoder. Compressed streams
// go in one byte per beat and a behavioral decoder predicts every output beat.
// A directed pass covers headers, every opcode and each error path, then
// random well-formed and damaged streams follow under random stalls, word
// size changes and one long output hold-off.
// ----------------------------------------------------------------------------
module run_increment_length_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rild_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [15:0] word_first;
    logic [15:0] word_second;
    logic [1:0]  word_count;
    status_t     status;
    logic        last;
    logic        fin;
  } decoded_beat_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_OVERRUN,
    FLAW_LONG_HEADER,
    FLAW_CUT,
    FLAW_TRAILING
  } flaw_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [1:0]  cfg_wr_data   = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  run_increment_length_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  decoded_beat_t   predicted_words[$];
  logic [7:0]      stream_bytes[$];
  int              mismatches  = 0;
  int              sent_beats  = 0;
  int              tx_calm     = 0;
  int              rx_calm     = 0;
  bit              hold_output = 1'b0;

  // decoder state mirror
  logic [1:0]      word_bytes_cfg = 2'd1;
  state_t          dec_phase;
  logic [2:0]      hdr_idx;
  longint unsigned hdr_acc;
  longint unsigned out_len;
  longint unsigned bytes_done;
  opcode_t         cur_op;
  logic [6:0]      words_left;
  logic [7:0]      low_byte;
  logic [15:0]     seed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_stream();
    dec_phase  = S_HEADER;
    hdr_idx    = '0;
    hdr_acc    = 0;
    out_len    = 0;
    bytes_done = 0;
    cur_op     = OP_COPY;
    words_left = '0;
    low_byte   = '0;
    seed       = '0;
  endfunction

  initial clear_stream();

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    decoded_beat_t step_q[$];
    decoded_beat_t beat;
    status_t       sts;
    bit            fin;
    bit            wide;
    bit            do_expand;
    bit            end_cmd;
    int unsigned   wb;
    int unsigned   exp_wb;
    logic [15:0]   mask;
    logic [15:0]   v;
    int            i;
    wide      = word_bytes_cfg[1];
    wb        = wide ? 2 : 1;
    sts       = STS_OK;
    fin       = 1'b0;
    do_expand = 1'b0;
    end_cmd   = 1'b0;
    exp_wb    = 1;
    mask      = 16'h00FF;
    case (dec_phase)
      S_HEADER: begin
        if (hdr_idx >= 1 && hdr_idx <= 3)
          hdr_acc = hdr_acc | (longint'(b) << (8 * (hdr_idx - 1)));
        hdr_idx = hdr_idx + 1;
        if (hdr_idx >= 4) begin
          hdr_idx   = 3'd4;
          out_len   = hdr_acc & ((64'd1 << LENGTH_BITS) - 1);
          dec_phase = S_CMD;
        end
      end
      S_CMD: begin
        cur_op     = opcode_t'(b[7:6]);
        words_left = (cur_op == OP_COPY) ? 7'(b[5:0]) + 7'd1 : 7'(b[5:0]) + 7'd3;
        if (!eos && bytes_done + longint'(words_left) * wb > out_len) begin
          sts       = STS_OVERRUN;
          dec_phase = S_ERROR;
        end else begin
          dec_phase = (cur_op == OP_COPY) ? S_COPY_LO : S_SEED_LO;
        end
      end
      S_COPY_LO: begin
        if (wide) begin
          low_byte  = b;
          dec_phase = S_COPY_HI;
        end else begin
          beat            = '0;
          beat.word_first = {8'h00, b};
          beat.word_count = 2'd1;
          step_q.push_back(beat);
          bytes_done += 1;
          if (words_left > 0) words_left = words_left - 1;
          if (words_left == 0) end_cmd = 1'b1;
        end
      end
      S_COPY_HI: begin
        beat            = '0;
        beat.word_first = {b, low_byte};
        beat.word_count = 2'd1;
        step_q.push_back(beat);
        bytes_done += 2;
        if (words_left > 0) words_left = words_left - 1;
        if (words_left == 0) end_cmd = 1'b1;
        else dec_phase = S_COPY_LO;
      end
      S_SEED_LO: begin
        if (wide) begin
          low_byte  = b;
          dec_phase = S_SEED_HI;
        end else begin
          seed      = {8'h00, b};
          do_expand = 1'b1;
        end
      end
      S_SEED_HI: begin
        seed      = {b, low_byte};
        mask      = 16'hFFFF;
        exp_wb    = 2;
        do_expand = 1'b1;
      end
      default: ;
    endcase

    if (do_expand) begin
      v = seed & mask;
      for (i = 0; i < words_left; i++) begin
        if (step_q.size() > 0 && step_q[step_q.size()-1].word_count == 2'd1) begin
          beat             = step_q[step_q.size()-1];
          beat.word_second = v;
          beat.word_count  = 2'd2;
          step_q[step_q.size()-1] = beat;
        end else begin
          beat            = '0;
          beat.word_first = v;
          beat.word_count = 2'd1;
          step_q.push_back(beat);
        end
        case (cur_op)
          OP_INC:  v = (v + 16'd1) & mask;
          OP_DEC:  v = (v + mask) & mask;
          default: ;
        endcase
      end
      bytes_done += longint'(words_left) * exp_wb;
      end_cmd = 1'b1;
    end

    if (end_cmd) begin
      words_left = '0;
      if (bytes_done == out_len) begin
        dec_phase = S_DONE;
        fin       = 1'b1;
      end else begin
        dec_phase = S_CMD;
      end
    end

    if (eos && sts == STS_OK && dec_phase != S_DONE && dec_phase != S_ERROR)
      sts = STS_SHORT;
    if (step_q.size() == 0 && (sts != STS_OK || fin))
      step_q.push_back('0);
    if (step_q.size() > 0) begin
      beat        = step_q[step_q.size()-1];
      beat.status = sts;
      beat.last   = 1'b1;
      beat.fin    = fin;
      step_q[step_q.size()-1] = beat;
    end
    foreach (step_q[k]) predicted_words.push_back(step_q[k]);
    if (eos) clear_stream();
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    sent_beats++;
    decode_byte(b, eos);
  endtask

  task automatic send_stream(input bit close_it);
    int k;
    for (k = 0; k < stream_bytes.size(); k++)
      send_beat(stream_bytes[k], close_it && (k == stream_bytes.size() - 1));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_word_bytes(input logic [1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    word_bytes_cfg = value;
  endtask

  task automatic build_stream(input int n_cmds, input bit force_long, input flaw_t flaw);
    logic [7:0]      body_q[$];
    opcode_t         op;
    logic [5:0]      len;
    longint unsigned total;
    longint unsigned hdr_len;
    int              c;
    int              w;
    int              n_words;
    int              wb;
    int              cut;
    wb    = word_bytes_cfg[1] ? 2 : 1;
    total = 0;
    for (c = 0; c < n_cmds; c++) begin
      op = opcode_t'($urandom_range(0, 3));
      if (force_long) len = 6'd63;
      else begin
        case ($urandom_range(0, 9))
          0:       len = 6'd63;
          1:       len = 6'd0;
          2:       len = 6'($urandom_range(0, 63));
          default: len = 6'($urandom_range(0, 7));
        endcase
      end
      body_q.push_back({op, len});
      n_words = (op == OP_COPY) ? len + 1 : len + 3;
      total += n_words * wb;
      for (w = 0; w < ((op == OP_COPY) ? n_words * wb : wb); w++)
        body_q.push_back(random_byte());
    end
    hdr_len = total;
    case (flaw)
      FLAW_OVERRUN:     hdr_len = total - $urandom_range(1, 32'(total));
      FLAW_LONG_HEADER: hdr_len = $urandom_range(0, 1) ? total + $urandom_range(1, 300)
                                                        : $urandom_range(32'(total) + 1,
                                                                         32'hFFFFFF);
      default: ;
    endcase
    stream_bytes.delete();
    stream_bytes.push_back(random_byte());
    stream_bytes.push_back(hdr_len[7:0]);
    stream_bytes.push_back(hdr_len[15:8]);
    stream_bytes.push_back(hdr_len[23:16]);
    foreach (body_q[k]) stream_bytes.push_back(body_q[k]);
    if (flaw == FLAW_CUT) begin
      cut = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
    if (flaw == FLAW_TRAILING)
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(random_byte());
  endtask

  task automatic test_directed_streams();
    // complete 8-bit stream: literal then decrement run wrapping below zero
    stream_bytes = '{8'hFF, 8'h05, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hC1, 8'h01};
    send_stream(1);
    // zero output length overruns, trailing byte ignored
    stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h40};
    send_stream(1);
    // stream shorter than its header
    stream_bytes = '{8'h00};
    send_stream(1);
    // 16-bit increment run wrapping past 0xFFFF
    write_word_bytes(2'd2);
    stream_bytes = '{8'h00, 8'h08, 8'h00, 8'h00, 8'h41, 8'hFF, 8'hFF};
    send_stream(1);
    // word size drops to 8 bits with a low byte held
    stream_bytes = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h34};
    send_stream(0);
    write_word_bytes(2'd0);
    send_beat(8'h12, 1'b1);
    // end of stream on a command byte wins over overrun
    stream_bytes = '{8'h3C, 8'h00, 8'h00, 8'h00, 8'hBF};
    send_stream(1);
  endtask

  task automatic test_random_streams();
    int    goal;
    int    stream_no;
    int    pick;
    flaw_t flaw;
    goal      = sent_beats + 300;
    stream_no = 0;
    while (sent_beats < goal) begin
      if (stream_no < 4) write_word_bytes(2'(stream_no));
      else if ($urandom_range(0, 3) == 0) write_word_bytes(2'($urandom_range(0, 3)));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        stream_bytes.delete();
        repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        case (pick)
          1:       flaw = FLAW_OVERRUN;
          2:       flaw = FLAW_LONG_HEADER;
          3:       flaw = FLAW_CUT;
          4:       flaw = FLAW_TRAILING;
          default: flaw = FLAW_NONE;
        endcase
        build_stream($urandom_range(1, 5), 1'b0, flaw);
      end
      send_stream(1);
      stream_no++;
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    hold_output = 1'b1;
    build_stream(2, 1'b1, FLAW_NONE);
    send_stream(1);
    wait_idle();
  endtask

  // result sink
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else if (rx_calm > 0) begin
        rx_calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // output beats are checked at the falling edge before the rising edge that takes them
  initial begin
    decoded_beat_t want;
    forever begin
      @(negedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (predicted_words.size() == 0) begin
          $error("unexpected result beat, data %0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = predicted_words.pop_front();
          check_field("word_first", want.word_first, m_axis_tdata[15:0]);
          check_field("word_second", want.word_second, m_axis_tdata[31:16]);
          check_field("word_count", 16'(want.word_count), 16'(m_axis_tdata[33:32]));
          check_field("status", 16'(want.status), 16'(m_axis_tdata[35:34]));
          check_field("pad", 16'd0, 16'(m_axis_tdata[39:36]));
          check_field("last_of_run", 16'(want.last), 16'(m_axis_tlast));
          check_field("finished", 16'(want.fin), 16'(m_axis_tuser[0]));
        end
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("run_increment_length_decoder regression: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_streams();
    test_random_streams();
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0)
      $display("run_increment_length_decoder regression: pass");
    else
      $display("run_increment_length_decoder regression: fail");
    $finish;
  end

endmodule

// ===== run_increment_length_decoder.f =====
rtl/core/rild_pkg.sv
rtl/core/rild_datapath.sv
rtl/core/rild_ctrl.sv
rtl/core/run_increment_length_decoder.sv
bench/run_increment_length_decoder_test.sv
